FILE: design/kccd_pkg.sv
// shared types, field widths and codes of the key chord combo detector
package kccd_pkg;

	localparam int EVW        = 9;   // event and key number width
	localparam int SLW        = 5;   // combo slot field width
	localparam int S_TDATA_W  = 40;  // 33 field bits padded to bytes
	localparam int M_TDATA_W  = 16;  // 13 field bits padded to bytes

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_SLOT_USED = 2'd1,
		STAT_BAD_KEY   = 2'd2,
		STAT_SAME_KEY  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_DEF1,
		ST_DEF2,
		ST_KEY,
		ST_P_OTHER,
		ST_P_COMBO,
		ST_R_PAIR,
		ST_R_MASK,
		ST_R_DOWN
	} state_t;

endpackage

FILE: design/kccd_ram.sv
// generic single-write, single-read ram with registered read data
module kccd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/key_chord_combo_detector_core.sv
// key chord combo detector top level: key and pair memories with a walk sequencer
//
// channel   dir  handshake          payload
// s_*       in   tvalid / tready    tuser: cmd; tdata: key_event, is_down, combo_index,
//                                   first_key, second_key
// m_*       out  tvalid / tready    tdata: out_event, out_down, cork, status; tlast: last
//
// steps: a press walks its new combos, a release walks its dying combos and adds a word
// when a held key is sent down again; each combo costs one pair-memory read followed by
// its output words
// reset: a clearing pass zeroes every key memory entry, s_tready low meanwhile
// stalls: one output register; the sequencer waits whenever it must load a word while the
// register holds an unaccepted one, and a new input word is taken as soon as it is idle
module key_chord_combo_detector_core #(
	parameter int KEY_EVENTS = 256,
	parameter int NUM_COMBOS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [8:0] key_event, [9] is_down, [14:10] combo_index, [23:15] first_key,
	// [32:24] second_key, rest zero
	input  logic [kccd_pkg::S_TDATA_W-1:0]   s_tdata,
	// [0] cmd
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [8:0] out_event, [9] out_down, [10] cork, [12:11] status, rest zero
	output logic [kccd_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                             m_tlast
);

	localparam int EVW = kccd_pkg::EVW;
	localparam int SLW = kccd_pkg::SLW;
	localparam int KW  = $clog2(KEY_EVENTS);   // stored key number width
	localparam int CW  = $clog2(NUM_COMBOS);   // combo slot index width
	localparam int NC  = NUM_COMBOS;
	localparam logic [EVW-1:0] KEY_LIMIT   = EVW'(KEY_EVENTS);
	localparam logic [EVW-1:0] EVENT_LIMIT = EVW'(KEY_EVENTS + NUM_COMBOS);
	localparam logic [KW:0]    KEY_LIMIT_K = (KW+1)'(KEY_EVENTS);
	localparam logic [SLW:0]   SLOT_LIMIT  = (SLW+1)'(NUM_COMBOS);

	// lowest set slot of a combo set
	function automatic logic [CW-1:0] lowest(input logic [NC-1:0] v);
		logic [CW-1:0] idx;
		idx = '0;
		for (int i = NC - 1; i >= 0; i--) begin
			if (v[i]) idx = CW'(i);
		end
		return idx;
	endfunction

	// sequencer state
	kccd_pkg::state_t state_q, state_d;
	logic [KW-1:0]    clr_q, clr_d;

	// combo sets held in flops
	logic [NC-1:0] half_q, half_d;
	logic [NC-1:0] full_q, full_d;
	logic [NC-1:0] alloc_q, alloc_d;
	logic [NC-1:0] walk_q, walk_d;   // combos still to be walked

	// captured input word and per-word working values
	logic [EVW-1:0]       ev_q, k1_q, k2_q;
	logic                 down_q;
	logic [SLW-1:0]       slot_q;
	logic                 cork_q, cork_d;
	kccd_pkg::status_t    status_q, status_d;
	logic [KW-1:0]        other_q, other_d;
	logic                 capture;

	// key memory: [NC] pressed, [NC-1:0] combo mask
	logic          key_we;
	logic [KW-1:0] key_waddr, key_raddr;
	logic [NC:0]   key_wdata, key_rd;

	// pair memory: [KW-1:0] first key, [2KW-1:KW] second key
	logic            pair_we;
	logic [CW-1:0]   pair_waddr, pair_raddr;
	logic [2*KW-1:0] pair_wdata, pair_rd;

	// output register
	logic                out_valid_q;
	logic [EVW-1:0]      out_event_q;
	logic                out_down_q, out_cork_q, out_last_q;
	kccd_pkg::status_t   out_status_q;
	logic                out_load, out_free;
	logic [EVW-1:0]      o_event;
	logic                o_down, o_cork, o_last;
	kccd_pkg::status_t   o_status;

	// decoded helpers
	logic [NC-1:0]  mine, cur_bit, rest, slot_bit, fresh, dying, new_half;
	logic [CW-1:0]  cur_c;
	logic [KW-1:0]  key_lo, partner;
	logic [EVW-1:0] combo_ev;
	logic           ev_in_keys, k1_ok, k2_ok, slot_ok, redown;

	kccd_ram #(.WIDTH(NC + 1), .DEPTH(KEY_EVENTS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.raddr (key_raddr),
		.rdata (key_rd)
	);

	kccd_ram #(.WIDTH(2 * KW), .DEPTH(NUM_COMBOS)) u_pair_ram (
		.clk   (clk),
		.we    (pair_we),
		.waddr (pair_waddr),
		.wdata (pair_wdata),
		.raddr (pair_raddr),
		.rdata (pair_rd)
	);

	assign mine       = key_rd[NC-1:0];
	assign key_lo     = ev_q[KW-1:0];
	assign partner    = (pair_rd[KW-1:0] == key_lo) ? pair_rd[2*KW-1:KW] : pair_rd[KW-1:0];
	assign cur_c      = lowest(walk_q);
	assign cur_bit    = NC'(1) << cur_c;
	assign rest       = walk_q & ~cur_bit;
	assign combo_ev   = KEY_LIMIT + EVW'(cur_c);
	assign slot_bit   = NC'(1) << slot_q[CW-1:0];
	assign ev_in_keys = ev_q < KEY_LIMIT;
	assign k1_ok      = k1_q < KEY_LIMIT;
	assign k2_ok      = k2_q < KEY_LIMIT;
	assign slot_ok    = {1'b0, slot_q} < SLOT_LIMIT;
	// press: combos whose other key is already held
	assign fresh      = mine & half_q & ~full_q;
	assign new_half   = half_q | mine;
	// release: asserted combos of this key
	assign dying      = mine & full_q;
	// held key goes back down when it is in no remaining asserted combo
	assign redown     = ({1'b0, other_q} < KEY_LIMIT_K) && (mine != '0) &&
	                    ((full_q & mine) == '0);
	assign out_free   = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kccd_pkg::ST_CLR;
			clr_q   <= '0;
			half_q  <= '0;
			full_q  <= '0;
			alloc_q <= '0;
			walk_q  <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			half_q  <= half_d;
			full_q  <= full_d;
			alloc_q <= alloc_d;
			walk_q  <= walk_d;
		end
	end

	// working values, no reset needed
	always_ff @(posedge clk) begin
		if (capture) begin
			ev_q   <= s_tdata[8:0];
			down_q <= s_tdata[9];
			slot_q <= s_tdata[14:10];
			k1_q   <= s_tdata[23:15];
			k2_q   <= s_tdata[32:24];
		end
		cork_q   <= cork_d;
		status_q <= status_d;
		other_q  <= other_d;
	end

	always_comb begin
		state_d    = state_q;
		clr_d      = clr_q;
		half_d     = half_q;
		full_d     = full_q;
		alloc_d    = alloc_q;
		walk_d     = walk_q;
		cork_d     = cork_q;
		status_d   = status_q;
		other_d    = other_q;
		capture    = 1'b0;
		s_tready   = 1'b0;
		key_we     = 1'b0;
		key_waddr  = key_lo;
		key_wdata  = key_rd;
		key_raddr  = key_lo;
		pair_we    = 1'b0;
		pair_waddr = slot_q[CW-1:0];
		pair_wdata = {k2_q[KW-1:0], k1_q[KW-1:0]};
		pair_raddr = cur_c;
		out_load   = 1'b0;
		o_event    = ev_q;
		o_down     = down_q;
		o_cork     = 1'b0;
		o_status   = kccd_pkg::STAT_OK;
		o_last     = 1'b1;

		unique case (state_q)
			kccd_pkg::ST_CLR: begin
				key_we    = 1'b1;
				key_waddr = clr_q;
				key_wdata = '0;
				clr_d     = clr_q + KW'(1);
				if (clr_q == KW'(KEY_EVENTS - 1)) state_d = kccd_pkg::ST_IDLE;
			end
			kccd_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				// start the key memory read from the incoming word
				key_raddr = s_tuser ? s_tdata[15 +: KW] : s_tdata[KW-1:0];
				if (s_tvalid) begin
					capture = 1'b1;
					if (s_tuser) begin
						state_d = kccd_pkg::ST_DEF1;
					end else if (s_tdata[8:0] < EVENT_LIMIT) begin
						state_d = kccd_pkg::ST_KEY;
					end
				end
			end
			kccd_pkg::ST_DEF1: begin
				// checks in order: slot, first key; second key next cycle
				key_raddr = k2_q[KW-1:0];
				state_d   = kccd_pkg::ST_DEF2;
				if (!slot_ok) begin
					status_d = kccd_pkg::STAT_BAD_KEY;
				end else if ((alloc_q & slot_bit) != '0) begin
					status_d = kccd_pkg::STAT_SLOT_USED;
				end else begin
					alloc_d = alloc_q | slot_bit;
					if (!k1_ok) begin
						status_d = kccd_pkg::STAT_BAD_KEY;
					end else begin
						status_d  = kccd_pkg::STAT_OK;
						key_we    = 1'b1;
						key_waddr = k1_q[KW-1:0];
						key_wdata = key_rd | {1'b0, slot_bit};
						pair_we   = 1'b1;
					end
				end
			end
			kccd_pkg::ST_DEF2: begin
				key_raddr = k2_q[KW-1:0];
				o_event   = '0;
				o_down    = 1'b0;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = kccd_pkg::ST_IDLE;
					if (status_q != kccd_pkg::STAT_OK) begin
						o_status = status_q;
					end else if (!k2_ok) begin
						o_status = kccd_pkg::STAT_BAD_KEY;
					end else if (k2_q == k1_q) begin
						// fresh slot: only the first key can hold its bit
						o_status = kccd_pkg::STAT_SAME_KEY;
					end else begin
						key_we    = 1'b1;
						key_waddr = k2_q[KW-1:0];
						key_wdata = key_rd | {1'b0, slot_bit};
					end
				end
			end
			kccd_pkg::ST_KEY: begin
				if (out_free) begin
					if (!ev_in_keys || mine == '0 || key_rd[NC] == down_q) begin
						out_load = 1'b1;
						state_d  = kccd_pkg::ST_IDLE;
					end else begin
						key_we    = 1'b1;
						key_wdata = {down_q, mine};
						if (down_q) begin
							half_d = new_half;
							full_d = full_q | fresh;
							cork_d = new_half != half_q;
							if (fresh == '0) begin
								out_load = 1'b1;
								o_cork   = new_half != half_q;
								state_d  = kccd_pkg::ST_IDLE;
							end else begin
								walk_d     = fresh;
								pair_raddr = lowest(fresh);
								state_d    = kccd_pkg::ST_P_OTHER;
							end
						end else begin
							full_d = full_q & ~dying;
							half_d = half_q & ~(mine & ~dying);
							cork_d = 1'b1;
							if (dying == '0) begin
								out_load = 1'b1;
								state_d  = kccd_pkg::ST_IDLE;
							end else begin
								walk_d     = dying;
								pair_raddr = lowest(dying);
								state_d    = kccd_pkg::ST_R_PAIR;
							end
						end
					end
				end
			end
			kccd_pkg::ST_P_OTHER: begin
				// first-pressed partner goes up before the combo goes down
				o_event = EVW'(partner);
				o_down  = 1'b0;
				o_cork  = cork_q;
				o_last  = 1'b0;
				if (partner != key_lo) begin
					if (out_free) begin
						out_load = 1'b1;
						state_d  = kccd_pkg::ST_P_COMBO;
					end
				end else begin
					state_d = kccd_pkg::ST_P_COMBO;
				end
			end
			kccd_pkg::ST_P_COMBO: begin
				pair_raddr = lowest(rest);
				o_event    = combo_ev;
				o_down     = 1'b1;
				o_cork     = cork_q;
				o_last     = rest == '0;
				if (out_free) begin
					out_load = 1'b1;
					walk_d   = rest;
					state_d  = (rest != '0) ? kccd_pkg::ST_P_OTHER : kccd_pkg::ST_IDLE;
				end
			end
			kccd_pkg::ST_R_PAIR: begin
				other_d   = partner;
				key_raddr = partner;
				state_d   = kccd_pkg::ST_R_MASK;
			end
			kccd_pkg::ST_R_MASK: begin
				key_raddr  = other_q;
				pair_raddr = lowest(rest);
				o_event    = combo_ev;
				o_down     = 1'b0;
				o_cork     = cork_q;
				o_last     = !redown && rest == '0;
				if (out_free) begin
					out_load = 1'b1;
					walk_d   = rest;
					if (redown) begin
						// remaining dying combos are dropped silently
						state_d = kccd_pkg::ST_R_DOWN;
					end else if (rest != '0) begin
						state_d = kccd_pkg::ST_R_PAIR;
					end else begin
						state_d = kccd_pkg::ST_IDLE;
					end
				end
			end
			kccd_pkg::ST_R_DOWN: begin
				o_event = EVW'(other_q);
				o_down  = 1'b1;
				o_cork  = cork_q;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = kccd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kccd_pkg::ST_IDLE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_event_q  <= o_event;
			out_down_q   <= o_down;
			out_cork_q   <= o_cork;
			out_status_q <= o_status;
			out_last_q   <= o_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_status_q, out_cork_q, out_down_q, out_event_q};
	assign m_tlast  = out_last_q;

endmodule

FILE: design/kccd_chk.sv
// port-level checker for the key chord combo detector and its bind
module kccd_chk #(
	parameter int KEY_EVENTS = 256,
	parameter int NUM_COMBOS = 32
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [kccd_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [kccd_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tlast
);

	localparam logic [8:0] EVENT_LIMIT = 9'(KEY_EVENTS + NUM_COMBOS);

	// a held output word does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// any word that is not dropped takes s_tready low in the cycle after it is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser || s_tdata[8:0] < EVENT_LIMIT) |=> !s_tready)
		else $error("input taken again right after a live word");

	// a word with an error status is a single define answer word with zero event fields
	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12:11] != kccd_pkg::STAT_OK |-> m_tlast && m_tdata[10:0] == '0)
		else $error("error status on a word that is not a define answer");

	// no output event from the dropped range
	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[8:0] < EVENT_LIMIT)
		else $error("output event number out of range");

endmodule

bind key_chord_combo_detector_core kccd_chk #(
	.KEY_EVENTS (KEY_EVENTS),
	.NUM_COMBOS (NUM_COMBOS)
) u_kccd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

FILE: sim/tb.sv
// self-checking testbench for the key chord combo detector core
`timescale 1ns / 100ps

module tb;

	localparam int KEY_EVENTS = 256;
	localparam int NUM_COMBOS = 32;
	localparam int EVW        = kccd_pkg::EVW;
	localparam int SLW        = kccd_pkg::SLW;
	localparam int S_TDATA_W  = kccd_pkg::S_TDATA_W;
	localparam int M_TDATA_W  = kccd_pkg::M_TDATA_W;
	localparam int MAX_RUN    = 64;       // most words one input word can cause
	localparam int LIMIT      = 300000;   // cycle budget for the whole run
	localparam int HOLD_LEN   = 300;      // long output stall to back up the input
	localparam int PER_PHASE  = 62;       // random words per idling phase, dropped words not counted

	// one output word: tdata fields plus tlast
	typedef struct packed {
		logic              last;
		kccd_pkg::status_t st;
		logic              cork;
		logic              down;
		logic [EVW-1:0]    num;
	} word_t;

	// how a directed row is checked
	typedef enum {ROW_PREDICT, ROW_ONE, ROW_NONE} row_kind_t;

	typedef struct {
		row_kind_t      kind;
		logic           cmd;
		logic [EVW-1:0] ev;
		logic           dn;
		logic [SLW-1:0] slot;
		logic [EVW-1:0] k1;
		logic [EVW-1:0] k2;
		word_t          want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;

	// chord tracking state of the predictor
	bit          held [KEY_EVENTS];
	logic [31:0] key_slots [KEY_EVENTS];
	logic [8:0]  pair_keys [NUM_COMBOS][2];
	logic [31:0] half_set;
	logic [31:0] full_set;
	logic [31:0] slots_taken;

	word_t step_words[$];     // words caused by the latest input word
	word_t pending[$];        // words still owed by the block, oldest first
	word_t want;

	int  mismatches = 0;
	int  cycles     = 0;
	int  tx_idle    = 26;     // percent of cycles the sender holds back
	int  rx_idle    = 56;     // percent of cycles the receiver stalls
	bit  hold_req   = 1'b0;
	bit  hold_done  = 1'b0;

	key_chord_combo_detector_core #(
		.KEY_EVENTS(KEY_EVENTS),
		.NUM_COMBOS(NUM_COMBOS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic word_t mk_word(int num, logic down, kccd_pkg::status_t st);
		word_t w;
		w.num  = num[EVW-1:0];
		w.down = down;
		w.cork = 1'b0;
		w.st   = st;
		w.last = 1'b1;
		return w;
	endfunction

	function automatic void add_word(int num, logic down);
		if (step_words.size() < MAX_RUN)
			step_words.push_back(mk_word(num, down, kccd_pkg::STAT_OK));
	endfunction

	// binds one key of a new pair; order of checks matters for partial failures
	function automatic kccd_pkg::status_t bind_key(logic [EVW-1:0] key, int slot, int which);
		if (key >= KEY_EVENTS)
			return kccd_pkg::STAT_BAD_KEY;
		if (key_slots[key][slot])
			return kccd_pkg::STAT_SAME_KEY;
		key_slots[key][slot] = 1'b1;
		pair_keys[slot][which] = key;
		return kccd_pkg::STAT_OK;
	endfunction

	function automatic kccd_pkg::status_t define_pair(int slot, logic [EVW-1:0] k1,
			logic [EVW-1:0] k2);
		kccd_pkg::status_t st;
		if (slot >= NUM_COMBOS)
			return kccd_pkg::STAT_BAD_KEY;
		if (slots_taken[slot])
			return kccd_pkg::STAT_SLOT_USED;
		slots_taken[slot] = 1'b1;
		st = bind_key(k1, slot, 0);
		if (st != kccd_pkg::STAT_OK)
			return st;
		return bind_key(k2, slot, 1);
	endfunction

	function automatic logic [8:0] mate(int c, logic [EVW-1:0] key);
		return (pair_keys[c][0] == key) ? pair_keys[c][1] : pair_keys[c][0];
	endfunction

	// works out every word that one accepted input word causes
	function automatic void chord_step(logic cmd, logic [EVW-1:0] ev, logic dn,
			logic [SLW-1:0] slot, logic [EVW-1:0] k1, logic [EVW-1:0] k2);
		logic [31:0]       prev_half, prev_full, mine, fresh, dying;
		logic [8:0]        other;
		logic              cork;
		kccd_pkg::status_t st;
		step_words = {};
		cork = 1'b0;
		if (cmd) begin
			st = define_pair(slot, k1, k2);
			step_words.push_back(mk_word(0, 1'b0, st));
		end else if (ev >= KEY_EVENTS + NUM_COMBOS) begin
			// dropped, no words
		end else if (ev >= KEY_EVENTS || key_slots[ev] == 0 || held[ev] == dn) begin
			add_word(ev, dn);
		end else if (dn) begin
			prev_half = half_set;
			prev_full = full_set;
			held[ev]  = 1'b1;
			mine      = key_slots[ev];
			full_set  = full_set | (mine & half_set);
			half_set  = half_set | mine;
			cork      = (prev_half != half_set);
			fresh     = full_set & ~prev_full;
			if (fresh == 0)
				add_word(ev, 1'b1);
			for (int c = 0; c < NUM_COMBOS; c++) begin
				if (fresh[c]) begin
					other = mate(c, ev);
					if (other != ev)
						add_word(other, 1'b0);
					add_word(KEY_EVENTS + c, 1'b1);
				end
			end
		end else begin
			held[ev] = 1'b0;
			mine     = key_slots[ev];
			dying    = mine & full_set;
			full_set = full_set & ~dying;
			half_set = half_set & ~(mine & ~dying);
			cork     = (dying != 0);
			if (dying == 0)
				add_word(ev, 1'b0);
			for (int c = 0; c < NUM_COMBOS; c++) begin
				if (dying[c]) begin
					add_word(KEY_EVENTS + c, 1'b0);
					other = mate(c, ev);
					// held partner alone again: send it down, the walk stops here
					if (other < KEY_EVENTS && key_slots[other] != 0 &&
							(full_set & key_slots[other]) == 0) begin
						add_word(other, 1'b1);
						break;
					end
				end
			end
		end
		foreach (step_words[i]) begin
			step_words[i].cork = cork;
			step_words[i].last = (i == step_words.size() - 1);
		end
	endfunction

	function automatic stim_row_t def_row(logic [SLW-1:0] slot, logic [EVW-1:0] k1,
			logic [EVW-1:0] k2, kccd_pkg::status_t st);
		stim_row_t r;
		r.kind = ROW_ONE;
		r.cmd  = 1'b1;
		r.ev   = 9'd0;
		r.dn   = 1'b0;
		r.slot = slot;
		r.k1   = k1;
		r.k2   = k2;
		r.want = mk_word(0, 1'b0, st);
		return r;
	endfunction

	// key row; a ROW_ONE row expects the word to pass through unchanged
	function automatic stim_row_t key_row(row_kind_t kind, logic [EVW-1:0] ev, logic dn);
		stim_row_t r;
		r.kind = kind;
		r.cmd  = 1'b0;
		r.ev   = ev;
		r.dn   = dn;
		r.slot = 5'd0;
		r.k1   = 9'd0;
		r.k2   = 9'd0;
		r.want = mk_word(ev, dn, kccd_pkg::STAT_OK);
		return r;
	endfunction

	// mostly a small key pool so pairs overlap and chords actually form
	function automatic logic [8:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return EVW'($urandom_range(0, 11));
		if (r < 90)
			return EVW'($urandom_range(0, KEY_EVENTS - 1));
		return EVW'($urandom_range(0, 511));
	endfunction

	// presents one input word and waits for its handshake
	task automatic offer(logic cmd, logic [EVW-1:0] ev, logic dn, logic [SLW-1:0] slot,
			logic [EVW-1:0] k1, logic [EVW-1:0] k2);
		while ($urandom_range(0, 99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(S_TDATA_W - 33){1'b0}}, k2, k1, slot, dn, ev};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off when asked
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				hold_done = 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
			end
			m_tready <= ($urandom_range(0, 99) >= rx_idle);
		end
	end

	// output checker: each accepted word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: tdata %h tlast %b", m_tdata, m_tlast);
			end else begin
				want = pending.pop_front();
				if (m_tdata !== {{(M_TDATA_W - 13){1'b0}}, want.st, want.cork, want.down,
						want.num} || m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: want ev %0d dn %0d cork %0d st %0d last %0d",
							want.num, want.down, want.cork, want.st, want.last);
						$display("  got ev %0d dn %0d cork %0d st %0d last %0d (tdata %h)",
							m_tdata[8:0], m_tdata[9], m_tdata[10], m_tdata[12:11],
							m_tlast, m_tdata);
					end
				end
			end
		end
	end

	initial begin
		stim_row_t      dir_tab[$];
		logic           cmd, dn;
		logic [EVW-1:0] ev, k1, k2;
		logic [SLW-1:0] slot;
		int             r, sent;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= 1'b0;
		s_tdata  <= '0;
		for (int i = 0; i < KEY_EVENTS; i++) begin
			held[i]      = 1'b0;
			key_slots[i] = '0;
		end
		for (int i = 0; i < NUM_COMBOS; i++) begin
			pair_keys[i][0] = '0;
			pair_keys[i][1] = '0;
		end
		half_set    = '0;
		full_set    = '0;
		slots_taken = '0;

		// pair definitions and their error codes
		dir_tab.push_back(def_row(5'd0, 9'd1, 9'd2, kccd_pkg::STAT_OK));
		dir_tab.push_back(def_row(5'd0, 9'd3, 9'd4, kccd_pkg::STAT_SLOT_USED));
		dir_tab.push_back(def_row(5'd1, 9'd300, 9'd5, kccd_pkg::STAT_BAD_KEY));
		dir_tab.push_back(def_row(5'd2, 9'd7, 9'd7, kccd_pkg::STAT_SAME_KEY));
		// failing second key leaves the first one bound
		dir_tab.push_back(def_row(5'd31, 9'd1, 9'd511, kccd_pkg::STAT_BAD_KEY));
		dir_tab.push_back(def_row(5'd4, 9'd1, 9'd3, kccd_pkg::STAT_OK));
		dir_tab.push_back(def_row(5'd5, 9'd2, 9'd3, kccd_pkg::STAT_OK));
		dir_tab.push_back(def_row(5'd3, 9'd0, 9'd255, kccd_pkg::STAT_OK));
		dir_tab.push_back(def_row(5'd6, 9'd0, 9'd11, kccd_pkg::STAT_OK));
		// out of range number is dropped, combo range and unbound keys pass through
		dir_tab.push_back(key_row(ROW_NONE, 9'd511, 1'b1));
		dir_tab.push_back(key_row(ROW_ONE, 9'd256, 1'b1));
		dir_tab.push_back(key_row(ROW_ONE, 9'd100, 1'b0));
		// chords over keys 1, 2, 3 with a repeated press in between
		dir_tab.push_back(key_row(ROW_PREDICT, 9'd1, 1'b1));
		dir_tab.push_back(key_row(ROW_ONE, 9'd1, 1'b1));
		dir_tab.push_back(key_row(ROW_PREDICT, 9'd2, 1'b1));
		dir_tab.push_back(key_row(ROW_PREDICT, 9'd3, 1'b1));
		dir_tab.push_back(key_row(ROW_PREDICT, 9'd1, 1'b0));
		dir_tab.push_back(key_row(ROW_PREDICT, 9'd3, 1'b0));
		dir_tab.push_back(key_row(ROW_PREDICT, 9'd2, 1'b0));
		// two chords at once on key 0, then a release that ends its walk early
		dir_tab.push_back(key_row(ROW_PREDICT, 9'd11, 1'b1));
		dir_tab.push_back(key_row(ROW_PREDICT, 9'd255, 1'b1));
		dir_tab.push_back(key_row(ROW_PREDICT, 9'd0, 1'b1));
		dir_tab.push_back(key_row(ROW_PREDICT, 9'd0, 1'b0));
		dir_tab.push_back(key_row(ROW_PREDICT, 9'd255, 1'b0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			offer(dir_tab[i].cmd, dir_tab[i].ev, dir_tab[i].dn, dir_tab[i].slot,
				dir_tab[i].k1, dir_tab[i].k2);
			chord_step(dir_tab[i].cmd, dir_tab[i].ev, dir_tab[i].dn, dir_tab[i].slot,
				dir_tab[i].k1, dir_tab[i].k2);
			if (dir_tab[i].kind == ROW_PREDICT)
				foreach (step_words[j]) pending.push_back(step_words[j]);
			else if (dir_tab[i].kind == ROW_ONE)
				pending.push_back(dir_tab[i].want);
		end

		// random part in three idling phases; the last one starts with the long hold
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				tx_idle = 56;
				rx_idle = 26;
			end else if (phase == 2) begin
				tx_idle = 0;
				rx_idle = 0;
				hold_req = 1'b1;
			end
			sent = 0;
			while (sent < PER_PHASE) begin
				cmd  = 1'b0;
				ev   = EVW'($urandom_range(0, 511));
				dn   = 1'($urandom_range(0, 1));
				slot = SLW'($urandom_range(0, 31));
				k1   = pick_key();
				k2   = pick_key();
				r    = $urandom_range(0, 99);
				if (r < 20) begin
					cmd = 1'b1;
				end else if (r >= 30) begin
					// pool key, mostly toggling its current state
					ev = EVW'($urandom_range(0, 11));
					if ($urandom_range(0, 9) != 0)
						dn = !held[ev];
				end
				offer(cmd, ev, dn, slot, k1, k2);
				chord_step(cmd, ev, dn, slot, k1, k2);
				foreach (step_words[j]) pending.push_back(step_words[j]);
				if (cmd || ev < KEY_EVENTS + NUM_COMBOS)
					sent++;
			end
		end
		s_tvalid <= 1'b0;

		while (pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: sim.f
design/kccd_pkg.sv
design/kccd_ram.sv
design/key_chord_combo_detector_core.sv
design/kccd_chk.sv
sim/tb.sv
